>>> hw/rtl/bpdr_pkg.sv
`default_nettype none
package bpdr_pkg;

  // Operand widths of the shared multiplier and divider.
  localparam int unsigned OPA_W = 128;
  localparam int unsigned OPB_W = 64;
  localparam int unsigned CHUNK_W = 32;

  // Fixed-point formats: discount factor work format and result format.
  localparam int unsigned WORK_BITS = 40;
  localparam int unsigned FRAC_BITS = 24;
  localparam int unsigned OUT_SHIFT = WORK_BITS - FRAC_BITS;

  // Period count width and the top bit index of the power loop.
  localparam int unsigned PERIOD_W = 10;
  localparam logic [3:0] N_TOP = 4'(PERIOD_W - 1);

  localparam logic [63:0] ONE_W = 64'd1 << WORK_BITS;
  localparam logic [127:0] HALF_LSB_W = 128'd1 << (WORK_BITS - 1);
  localparam logic [23:0] RATE_SCALE = 24'd1000000;
  localparam logic signed [25:0] DV01_STEP = 26'sd100;
  localparam logic [63:0] RISK_DIV = 64'd100;
  localparam logic [127:0] RISK_RND = 128'd50;
  localparam logic [63:0] INT64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] INT64_MIN = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    CMD_PRICE = 2'd0,
    CMD_DV01  = 2'd1,
    CMD_RISK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

endpackage
`default_nettype wire

>>> hw/rtl/bpdr_mul.sv
`default_nettype none
// Iterative multiplier: p = c + a * b (mod 2^128), one 32x32 partial
// product per cycle until all chunk pairs are summed.
module bpdr_mul (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic [bpdr_pkg::OPA_W-1:0]      a_i,
  input  wire logic [bpdr_pkg::OPB_W-1:0]      b_i,
  input  wire logic [bpdr_pkg::OPA_W-1:0]      c_i,
  output logic                                 done_o,
  output logic [bpdr_pkg::OPA_W-1:0]           p_o
);

  logic [bpdr_pkg::OPA_W-1:0] a_q, acc_q;
  logic [bpdr_pkg::OPB_W-1:0] b_q;
  logic [2:0] cnt_q;
  logic busy_q, done_q;
  logic [31:0] a_chunk, b_chunk;
  logic [63:0] pp;
  logic [2:0] pos;
  logic [127:0] sh;

  // Select the chunk pair for this cycle and align the partial product.
  // Chunks that land at bit 128 or above drop out of the result.
  always_comb begin
    a_chunk = a_q[{cnt_q[2:1], 5'b0} +: bpdr_pkg::CHUNK_W];
    b_chunk = b_q[{cnt_q[0], 5'b0} +: bpdr_pkg::CHUNK_W];
    pp = 64'(a_chunk) * 64'(b_chunk);
    pos = {1'b0, cnt_q[2:1]} + {2'b0, cnt_q[0]};
    sh = {64'd0, pp} << {pos, 5'b0};
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= 3'd0;
    end else begin
      done_q <= busy_q && (cnt_q == 3'd7);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= 3'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 3'd1;
        if (cnt_q == 3'd7) busy_q <= 1'b0;
      end
    end
  end

  // Operands and accumulator.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      acc_q <= c_i;
    end else if (busy_q) begin
      acc_q <= acc_q + sh;
    end
  end

  assign done_o = done_q;
  assign p_o = acc_q;

endmodule
`default_nettype wire

>>> hw/rtl/bpdr_div.sv
`default_nettype none
// Restoring divider: 128-bit dividend by a 64-bit divisor below 2^63,
// one quotient bit per cycle.
module bpdr_div (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [bpdr_pkg::OPA_W-1:0]  dividend_i,
  input  wire logic [bpdr_pkg::OPB_W-1:0]  divisor_i,
  output logic                             done_o,
  output logic [bpdr_pkg::OPA_W-1:0]       quot_o
);

  logic [bpdr_pkg::OPA_W-1:0] n_q;
  logic [bpdr_pkg::OPB_W-1:0] d_q, rem_q;
  logic [6:0] cnt_q;
  logic busy_q, done_q;
  logic [64:0] trial;
  logic ge;

  // One shift-and-subtract step.
  always_comb begin
    trial = {rem_q, n_q[bpdr_pkg::OPA_W-1]};
    ge = trial >= {1'b0, d_q};
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= 7'd0;
    end else begin
      done_q <= busy_q && (cnt_q == 7'd127);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= 7'd0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 7'd1;
        if (cnt_q == 7'd127) busy_q <= 1'b0;
      end
    end
  end

  // Datapath: the dividend register fills with quotient bits.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      n_q <= dividend_i;
      d_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? 64'(trial - {1'b0, d_q}) : trial[63:0];
      n_q <= {n_q[bpdr_pkg::OPA_W-2:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = n_q;

endmodule
`default_nettype wire

>>> hw/rtl/bond_price_dv01_risk_top.sv
`default_nettype none
// Bond price, DV01 and position risk in signed fixed point (24 fraction bits).
// Input channel: in_valid_i/in_ready_o with command, frequency, coupon rate,
// face value, yield, period count and position amount. Output channel:
// out_valid_o/out_ready_i with value and the zero_coupon, math_error and
// saturated flags. One result per transfer in.
// A sequencer drives one iterative multiplier and one serial divider. A price
// evaluation costs one division for the per-period discount ratio, 10 to 20
// products for the power by squaring, up to three products for the numerator
// and one final division. DV01 runs two evaluations and risk adds one product
// and one division by 100. Errors end the item early.
// in_ready_o is high only while the sequencer is idle; an item is taken while
// the previous result still waits in the output register. If the receiver
// stalls, the finished item holds in the sequencer until the output register
// frees. Reset clears the sequencer and the output valid.
module bond_price_dv01_risk_top (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [1:0]          command_i,
  input  wire logic [3:0]          frequency_i,
  input  wire logic [23:0]         coupon_rate_i,
  input  wire logic [30:0]         face_value_i,
  input  wire logic signed [24:0]  yield_rate_i,
  input  wire logic [9:0]          period_count_i,
  input  wire logic signed [31:0]  position_amount_i,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic signed [63:0]       value_o,
  output logic                     zero_coupon_o,
  output logic                     math_error_o,
  output logic                     saturated_o
);

  typedef enum logic [16:0] {
    S_IDLE  = 17'h00001,
    S_SETUP = 17'h00002,
    S_RGOT  = 17'h00004,
    S_WSTEP = 17'h00008,
    S_WGOT  = 17'h00010,
    S_NUMS  = 17'h00020,
    S_NUMY  = 17'h00040,
    S_NUMF  = 17'h00080,
    S_RND   = 17'h00100,
    S_QGOT  = 17'h00200,
    S_EVAL  = 17'h00400,
    S_RISKM = 17'h00800,
    S_RISKD = 17'h01000,
    S_RISKQ = 17'h02000,
    S_OUT   = 17'h04000,
    S_MWAIT = 17'h08000,
    S_DWAIT = 17'h10000
  } state_e;

  state_e state_q, state_d, ret_q, ret_d;
  logic out_valid_q, out_valid_d;

  logic [1:0] cmd_q, cmd_d;
  logic [3:0] f_q, f_d;
  logic [23:0] cr_q, cr_d;
  logic [30:0] face_q, face_d;
  logic signed [24:0] yr_q, yr_d;
  logic [9:0] n_q, n_d;
  logic signed [31:0] amt_q, amt_d;
  logic pass_q, pass_d, err_q, err_d, sat_q, sat_d, phase_q, phase_d;
  logic [3:0] idx_q, idx_d;
  logic [63:0] r_q, r_d, w_q, w_d, price_q, price_d, p1_q, p1_d;
  logic [63:0] dv_q, dv_d, val_q, val_d;
  logic [127:0] res_q, res_d;
  logic [63:0] ov_q, ov_d;
  logic oz_q, oz_d, oe_q, oe_d, os_q, os_d;

  logic mul_start, mul_done, div_start, div_done;
  logic [127:0] mul_a, mul_c, mul_p, div_n, div_q;
  logic [63:0] mul_b, div_d;

  logic zc;
  logic signed [25:0] yev;
  logic [23:0] p_val;
  logic signed [26:0] b_val;
  logic [25:0] ay;
  logic [63:0] dw, dvs, mdv;
  logic [31:0] mam;
  logic [64:0] diff, diffr;
  logic neg;

  bpdr_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .a_i(mul_a), .b_i(mul_b), .c_i(mul_c),
    .done_o(mul_done), .p_o(mul_p)
  );

  bpdr_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .dividend_i(div_n), .divisor_i(div_d),
    .done_o(div_done), .quot_o(div_q)
  );

  // Quantities derived from the item held in the working registers.
  always_comb begin
    zc = (cr_q == '0) || (face_q == '0);
    if (cmd_q == bpdr_pkg::CMD_PRICE) yev = {yr_q[24], yr_q};
    else if (pass_q) yev = {yr_q[24], yr_q} + bpdr_pkg::DV01_STEP;
    else yev = {yr_q[24], yr_q} - bpdr_pkg::DV01_STEP;
    p_val = 24'(f_q) * bpdr_pkg::RATE_SCALE;
    b_val = $signed({3'b0, p_val}) + {yev[25], yev};
    ay = yev[25] ? 26'(-yev) : 26'(yev);
    dw = (w_q >= bpdr_pkg::ONE_W) ? w_q - bpdr_pkg::ONE_W : bpdr_pkg::ONE_W - w_q;
    dvs = zc ? (64'd1 << bpdr_pkg::OUT_SHIFT) : (64'(ay) << bpdr_pkg::OUT_SHIFT);
    diff = {p1_q[63], p1_q} - {price_q[63], price_q};
    diffr = diff + {64'd0, diff[64]};
    mdv = dv_q[63] ? 64'(-dv_q) : dv_q;
    mam = amt_q[31] ? 32'(-amt_q) : 32'(amt_q);
    neg = dv_q[63] != amt_q[31];
  end

  // Sequencer.
  always_comb begin
    state_d = state_q; ret_d = ret_q; out_valid_d = out_valid_q;
    cmd_d = cmd_q; f_d = f_q; cr_d = cr_q; face_d = face_q; yr_d = yr_q;
    n_d = n_q; amt_d = amt_q; pass_d = pass_q; err_d = err_q; sat_d = sat_q;
    phase_d = phase_q; idx_d = idx_q; r_d = r_q; w_d = w_q; price_d = price_q;
    p1_d = p1_q; dv_d = dv_q; val_d = val_q; res_d = res_q;
    ov_d = ov_q; oz_d = oz_q; oe_d = oe_q; os_d = os_q;
    mul_start = 1'b0; mul_a = '0; mul_b = '0; mul_c = '0;
    div_start = 1'b0; div_n = '0; div_d = '0;
    if (out_valid_q && out_ready_i) out_valid_d = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_d = command_i; f_d = frequency_i; cr_d = coupon_rate_i;
          face_d = face_value_i; yr_d = yield_rate_i; n_d = period_count_i;
          amt_d = position_amount_i;
          pass_d = 1'b0; err_d = 1'b0; sat_d = 1'b0; val_d = '0;
          state_d = (command_i == bpdr_pkg::CMD_NONE) ? S_OUT : S_SETUP;
        end
      end
      // Range checks, then the discount ratio r = P / (P + y).
      S_SETUP: begin
        if (f_q == '0 || b_val[26] || b_val == '0 || (!zc && yev == '0)) begin
          err_d = 1'b1;
          state_d = S_OUT;
        end else begin
          div_start = 1'b1;
          div_n = {64'd0, p_val, 40'd0} + {103'd0, b_val[25:1]};
          div_d = {37'd0, b_val};
          ret_d = S_RGOT;
          state_d = S_DWAIT;
        end
      end
      S_RGOT: begin
        r_d = res_q[63:0];
        w_d = bpdr_pkg::ONE_W;
        idx_d = bpdr_pkg::N_TOP;
        phase_d = 1'b0;
        state_d = S_WSTEP;
      end
      // Power by squaring, most significant period bit first.
      S_WSTEP: begin
        mul_start = 1'b1;
        mul_a = {64'd0, w_q};
        mul_b = phase_q ? r_q : w_q;
        mul_c = bpdr_pkg::HALF_LSB_W;
        ret_d = S_WGOT;
        state_d = S_MWAIT;
      end
      S_WGOT: begin
        if (|res_q[127:64+bpdr_pkg::WORK_BITS]) begin
          price_d = (face_q == '0) ? 64'd0 : bpdr_pkg::INT64_MAX;
          if (face_q != '0) sat_d = 1'b1;
          state_d = S_EVAL;
        end else begin
          w_d = res_q[bpdr_pkg::WORK_BITS +: 64];
          if (!phase_q && n_q[idx_q]) begin
            phase_d = 1'b1;
            state_d = S_WSTEP;
          end else if (idx_q == '0) begin
            state_d = S_NUMS;
          end else begin
            idx_d = idx_q - 4'd1;
            phase_d = 1'b0;
            state_d = S_WSTEP;
          end
        end
      end
      // Numerator: face * w, or face * (w * |y| + coupon * |1 - w|).
      S_NUMS: begin
        mul_start = 1'b1;
        mul_a = zc ? {64'd0, w_q} : {64'd0, dw};
        mul_b = zc ? {33'd0, face_q} : {40'd0, cr_q};
        ret_d = zc ? S_RND : S_NUMY;
        state_d = S_MWAIT;
      end
      S_NUMY: begin
        mul_start = 1'b1;
        mul_a = {64'd0, w_q};
        mul_b = {38'd0, ay};
        mul_c = res_q;
        ret_d = S_NUMF;
        state_d = S_MWAIT;
      end
      S_NUMF: begin
        mul_start = 1'b1;
        mul_a = res_q;
        mul_b = {33'd0, face_q};
        ret_d = S_RND;
        state_d = S_MWAIT;
      end
      S_RND: begin
        div_start = 1'b1;
        div_n = res_q + {64'd0, dvs >> 1};
        div_d = dvs;
        ret_d = S_QGOT;
        state_d = S_DWAIT;
      end
      S_QGOT: begin
        if (|res_q[127:63]) begin
          price_d = bpdr_pkg::INT64_MAX;
          sat_d = 1'b1;
        end else begin
          price_d = res_q[63:0];
        end
        state_d = S_EVAL;
      end
      // One evaluation is complete: finish, run the second, or form DV01.
      S_EVAL: begin
        if (cmd_q == bpdr_pkg::CMD_PRICE) begin
          val_d = price_q;
          state_d = S_OUT;
        end else if (!pass_q) begin
          p1_d = price_q;
          pass_d = 1'b1;
          state_d = S_SETUP;
        end else if (cmd_q == bpdr_pkg::CMD_DV01) begin
          val_d = diffr[64:1];
          state_d = S_OUT;
        end else begin
          dv_d = diffr[64:1];
          state_d = S_RISKM;
        end
      end
      S_RISKM: begin
        mul_start = 1'b1;
        mul_a = {64'd0, mdv};
        mul_b = {32'd0, mam};
        mul_c = bpdr_pkg::RISK_RND;
        ret_d = S_RISKD;
        state_d = S_MWAIT;
      end
      S_RISKD: begin
        div_start = 1'b1;
        div_n = res_q;
        div_d = bpdr_pkg::RISK_DIV;
        ret_d = S_RISKQ;
        state_d = S_DWAIT;
      end
      S_RISKQ: begin
        if (!neg) begin
          if (|res_q[127:63]) begin
            val_d = bpdr_pkg::INT64_MAX;
            sat_d = 1'b1;
          end else begin
            val_d = res_q[63:0];
          end
        end else if ((|res_q[127:64]) || (res_q[63] && (|res_q[62:0]))) begin
          val_d = bpdr_pkg::INT64_MIN;
          sat_d = 1'b1;
        end else begin
          val_d = 64'(-res_q[63:0]);
        end
        state_d = S_OUT;
      end
      // Hand the result to the output register once it is free.
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          ov_d = err_q ? 64'd0 : val_q;
          oz_d = zc;
          oe_d = err_q;
          os_d = err_q ? 1'b0 : sat_q;
          state_d = S_IDLE;
        end
      end
      S_MWAIT: begin
        if (mul_done) begin
          res_d = mul_p;
          state_d = ret_q;
        end
      end
      S_DWAIT: begin
        if (div_done) begin
          res_d = div_q;
          state_d = ret_q;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q <= ret_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and output payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; f_q <= f_d; cr_q <= cr_d; face_q <= face_d; yr_q <= yr_d;
    n_q <= n_d; amt_q <= amt_d; pass_q <= pass_d; err_q <= err_d; sat_q <= sat_d;
    phase_q <= phase_d; idx_q <= idx_d; r_q <= r_d; w_q <= w_d;
    price_q <= price_d; p1_q <= p1_d; dv_q <= dv_d; val_q <= val_d;
    res_q <= res_d; ov_q <= ov_d; oz_q <= oz_d; oe_q <= oe_d; os_q <= os_d;
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign value_o = ov_q;
  assign zero_coupon_o = oz_q;
  assign math_error_o = oe_q;
  assign saturated_o = os_q;

endmodule
`default_nettype wire

>>> tb/bond_price_dv01_risk_top_tb.sv
`timescale 1ns / 1ps

module bond_price_dv01_risk_top_tb;

  typedef struct {
    logic [63:0] value;
    logic        zero_coupon;
    logic        math_error;
    logic        saturated;
  } bond_result_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         command_i = '0;
  logic [3:0]         frequency_i = '0;
  logic [23:0]        coupon_rate_i = '0;
  logic [30:0]        face_value_i = '0;
  logic signed [24:0] yield_rate_i = '0;
  logic [9:0]         period_count_i = '0;
  logic signed [31:0] position_amount_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [63:0] value_o;
  logic               zero_coupon_o;
  logic               math_error_o;
  logic               saturated_o;

  bond_result_t expected_results[$];
  int unsigned  mismatch_count = 0;
  int unsigned  item_count = 0;
  int unsigned  result_count = 0;
  int unsigned  error_results = 0;
  int unsigned  sat_results = 0;
  bit           steady_flow = 1'b0;

  bond_price_dv01_risk_top u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .command_i         (command_i),
    .frequency_i       (frequency_i),
    .coupon_rate_i     (coupon_rate_i),
    .face_value_i      (face_value_i),
    .yield_rate_i      (yield_rate_i),
    .period_count_i    (period_count_i),
    .position_amount_i (position_amount_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .value_o           (value_o),
    .zero_coupon_o     (zero_coupon_o),
    .math_error_o      (math_error_o),
    .saturated_o       (saturated_o)
  );

  always #10 clk_i = ~clk_i;

  // Fixed-point product with half-up rounding to 40 fraction bits.
  function automatic logic [63:0] mul_work(logic [63:0] a, logic [63:0] b, inout bit huge);
    logic [127:0] prod;
    prod = {64'd0, a} * {64'd0, b};
    prod = prod + bpdr_pkg::HALF_LSB_W;
    if (prod[127:104] != '0) begin
      huge = 1'b1;
      return '1;
    end
    return prod[103:40];
  endfunction

  // Clean price at one yield; flags accumulate across calls.
  function automatic logic [63:0] bond_price(logic [23:0] cr, logic [30:0] face,
                                             longint yr, logic [3:0] freq, int n,
                                             inout bit err, inout bit sat);
    bit           zc, huge;
    logic [63:0]  scale, base, ratio, disc, ay, gap, divisor;
    logic [127:0] num, quot, cterm;
    zc = (cr == 0) || (face == 0);
    huge = 1'b0;
    if (freq == 0) begin
      err = 1'b1;
      return '0;
    end
    scale = 64'(bpdr_pkg::RATE_SCALE) * freq;
    if (longint'(scale) + yr <= 0) begin
      err = 1'b1;
      return '0;
    end
    if (!zc && yr == 0) begin
      err = 1'b1;
      return '0;
    end
    base = scale + yr;
    ratio = ((scale << bpdr_pkg::WORK_BITS) + base / 2) / base;
    disc = bpdr_pkg::ONE_W;
    for (int i = 15; i >= 0; i--) begin
      if (!huge) disc = mul_work(disc, disc, huge);
      if (!huge && n[i]) disc = mul_work(disc, ratio, huge);
    end
    if (huge) begin
      if (face == 0) return '0;
      sat = 1'b1;
      return bpdr_pkg::INT64_MAX;
    end
    if (zc) begin
      num = {64'd0, disc} * {97'd0, face};
      divisor = 64'd1 << bpdr_pkg::OUT_SHIFT;
    end else begin
      ay = (yr < 0) ? 64'(-yr) : 64'(yr);
      gap = (disc >= bpdr_pkg::ONE_W) ? disc - bpdr_pkg::ONE_W : bpdr_pkg::ONE_W - disc;
      cterm = {104'd0, cr} * {64'd0, gap};
      num = {64'd0, disc} * {64'd0, ay} + cterm;
      num = num * {97'd0, face};
      divisor = ay << bpdr_pkg::OUT_SHIFT;
    end
    num = num + divisor / 2;
    quot = num / {64'd0, divisor};
    if (quot[127:64] != '0 || quot[63]) begin
      sat = 1'b1;
      return bpdr_pkg::INT64_MAX;
    end
    return quot[63:0];
  endfunction

  function automatic bond_result_t predict_result(bpdr_pkg::cmd_e cmd, logic [3:0] freq,
                                                  logic [23:0] cr, logic [30:0] face,
                                                  logic signed [24:0] yr,
                                                  logic [9:0] periods,
                                                  logic signed [31:0] amount);
    bond_result_t res;
    bit           err, sat, neg;
    longint       lo_price, hi_price, dv;
    logic [63:0]  mag_dv, mag_amt;
    logic [127:0] quot;
    err = 1'b0;
    sat = 1'b0;
    res.value = '0;
    unique case (cmd)
      bpdr_pkg::CMD_PRICE: begin
        res.value = bond_price(cr, face, yr, freq, periods, err, sat);
      end
      bpdr_pkg::CMD_DV01, bpdr_pkg::CMD_RISK: begin
        lo_price = bond_price(cr, face, longint'(yr) - 100, freq, periods, err, sat);
        hi_price = bond_price(cr, face, longint'(yr) + 100, freq, periods, err, sat);
        dv = (lo_price - hi_price) / 2;
        if (cmd == bpdr_pkg::CMD_DV01) begin
          res.value = dv;
        end else begin
          neg = (dv < 0) != (amount < 0);
          mag_dv = (dv < 0) ? 64'(-dv) : 64'(dv);
          mag_amt = (amount < 0) ? 64'(-longint'(amount)) : 64'(amount);
          quot = ({64'd0, mag_dv} * {64'd0, mag_amt} + bpdr_pkg::RISK_RND)
                 / {64'd0, bpdr_pkg::RISK_DIV};
          if (!neg) begin
            if (quot[127:64] != '0 || quot[63]) begin
              sat = 1'b1;
              res.value = bpdr_pkg::INT64_MAX;
            end else begin
              res.value = quot[63:0];
            end
          end else begin
            if (quot[127:64] != '0 || quot[63:0] > bpdr_pkg::INT64_MIN) begin
              sat = 1'b1;
              res.value = bpdr_pkg::INT64_MIN;
            end else begin
              res.value = -quot[63:0];
            end
          end
        end
      end
      default: begin
        res.value = '0;
      end
    endcase
    if (err) begin
      res.value = '0;
      sat = 1'b0;
    end
    res.zero_coupon = (cr == 0) || (face == 0);
    res.math_error = err;
    res.saturated = sat;
    return res;
  endfunction

  // Sends one bond item; valid stays up until the transfer.
  task automatic send_bond(bpdr_pkg::cmd_e cmd, logic [3:0] freq, logic [23:0] cr,
                           logic [30:0] face, logic signed [24:0] yr,
                           logic [9:0] periods, logic signed [31:0] amount);
    if (!steady_flow && $urandom_range(99) < 12) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    frequency_i <= freq;
    coupon_rate_i <= cr;
    face_value_i <= face;
    yield_rate_i <= yr;
    period_count_i <= periods;
    position_amount_i <= amount;
    do @(posedge clk_i); while (!in_ready_o);
    expected_results.push_back(predict_result(cmd, freq, cr, face, yr, periods, amount));
    item_count++;
  endtask

  // Random receiver stalls, none while the steady stretch runs.
  always @(posedge clk_i) begin
    out_ready_i <= steady_flow ? 1'b1 : ($urandom_range(99) >= 12);
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    bond_result_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      result_count++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result value %h", $time, value_o);
        mismatch_count++;
      end else begin
        exp_res = expected_results.pop_front();
        if (exp_res.math_error) error_results++;
        if (exp_res.saturated) sat_results++;
        if (value_o !== exp_res.value) begin
          $display("%0t: value expected %h actual %h", $time, exp_res.value, value_o);
          mismatch_count++;
        end
        if (zero_coupon_o !== exp_res.zero_coupon) begin
          $display("%0t: zero_coupon expected %b actual %b", $time,
                   exp_res.zero_coupon, zero_coupon_o);
          mismatch_count++;
        end
        if (math_error_o !== exp_res.math_error) begin
          $display("%0t: math_error expected %b actual %b", $time,
                   exp_res.math_error, math_error_o);
          mismatch_count++;
        end
        if (saturated_o !== exp_res.saturated) begin
          $display("%0t: saturated expected %b actual %b", $time,
                   exp_res.saturated, saturated_o);
          mismatch_count++;
        end
      end
    end
  end

  // Field extremes, every command and common bonds.
  task automatic test_extremes();
    send_bond(bpdr_pkg::CMD_PRICE, 4'd2, 24'd50000, 31'd1000, 25'sd40000, 10'd20, 32'sd1);
    send_bond(bpdr_pkg::CMD_DV01, 4'd2, 24'd50000, 31'd1000, 25'sd40000, 10'd20, 32'sd1);
    send_bond(bpdr_pkg::CMD_RISK, 4'd2, 24'd50000, 31'd1000, 25'sd40000, 10'd20,
              32'sd1000000);
    send_bond(bpdr_pkg::CMD_RISK, 4'd1, 24'd10000000, 31'h7FFFFFFF, 25'sd10000000,
              10'd1023, 32'h80000000);
    send_bond(bpdr_pkg::CMD_RISK, 4'd12, 24'hFFFFFF, 31'h7FFFFFFF, 25'sd30000, 10'd1023,
              32'h7FFFFFFF);
    send_bond(bpdr_pkg::CMD_RISK, 4'd4, 24'd60000, 31'h7FFFFFFF, 25'sd50000, 10'd40,
              32'sh80000000);
    send_bond(bpdr_pkg::CMD_PRICE, 4'd1, 24'd1, 31'd1, 25'sd1, 10'd0, 32'sd0);
    send_bond(bpdr_pkg::CMD_NONE, 4'd3, 24'd50000, 31'd100, 25'sd10000, 10'd5, 32'sd7);
    send_bond(bpdr_pkg::CMD_PRICE, 4'd15, 24'd30000, 31'd5000, 25'sh0FFFFFF, 10'd300,
              32'sd0);
    send_bond(bpdr_pkg::CMD_DV01, 4'd13, 24'd30000, 31'd5000, 25'sd50000, 10'd100, 32'sd0);
  endtask

  // Errors, zero coupons and huge discount factors.
  task automatic test_special_cases();
    send_bond(bpdr_pkg::CMD_PRICE, 4'd2, 24'd50000, 31'd1000, 25'sd0, 10'd10, 32'sd0);
    send_bond(bpdr_pkg::CMD_DV01, 4'd1, 24'd50000, 31'd1000, 25'sd100, 10'd10, 32'sd0);
    send_bond(bpdr_pkg::CMD_PRICE, 4'd0, 24'd50000, 31'd1000, 25'sd30000, 10'd10, 32'sd0);
    send_bond(bpdr_pkg::CMD_PRICE, 4'd1, 24'd50000, 31'd1000, -25'sd1000000, 10'd10,
              32'sd0);
    send_bond(bpdr_pkg::CMD_RISK, 4'd1, 24'd50000, 31'd1000, -25'sd10000000, 10'd10,
              32'sd5);
    send_bond(bpdr_pkg::CMD_PRICE, 4'd2, 24'd0, 31'd1000, 25'sd0, 10'd10, 32'sd0);
    send_bond(bpdr_pkg::CMD_PRICE, 4'd2, 24'd40000, 31'd0, 25'sd30000, 10'd10, 32'sd0);
    send_bond(bpdr_pkg::CMD_DV01, 4'd1, 24'd0, 31'd1000000, 25'sd50000, 10'd30, 32'sd0);
    send_bond(bpdr_pkg::CMD_PRICE, 4'd1, 24'd50000, 31'd1000, -25'sd999000, 10'd1023,
              32'sd0);
    send_bond(bpdr_pkg::CMD_PRICE, 4'd1, 24'd0, 31'd0, -25'sd999000, 10'd1023, 32'sd0);
    send_bond(bpdr_pkg::CMD_RISK, 4'd1, 24'd50000, 31'd1000, -25'sd900000, 10'd1023,
              -32'sd3);
    send_bond(bpdr_pkg::CMD_PRICE, 4'd1, 24'd50000, 31'd1000, -25'sd16777216, 10'd5,
              32'sd0);
  endtask

  // Mostly realistic bonds, some raw full-width noise.
  task automatic test_random(int unsigned count);
    logic signed [24:0] yr;
    logic [23:0]        cr;
    logic [30:0]        face;
    logic [9:0]         periods;
    logic [3:0]         freq;
    for (int unsigned i = 0; i < count; i++) begin
      if ($urandom_range(99) < 75) begin
        freq = 4'($urandom_range(1, 12));
        cr = ($urandom_range(9) == 0) ? 24'd0 : 24'($urandom_range(0, 150000));
        face = ($urandom_range(19) == 0) ? 31'd0 : 31'($urandom_range(1, 100000000));
        yr = 25'($urandom_range(0, 300000)) - 25'sd50000;
        periods = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 120));
      end else begin
        freq = 4'($urandom);
        cr = ($urandom_range(1) == 0) ? 24'($urandom) : 24'($urandom_range(0, 10000000));
        face = 31'($urandom);
        yr = ($urandom_range(1) == 0) ? 25'($urandom)
                                      : 25'($urandom_range(0, 20000000)) - 25'sd10000000;
        periods = 10'($urandom);
      end
      send_bond(bpdr_pkg::cmd_e'($urandom_range(9) == 0 ? 3 : $urandom_range(0, 2)), freq,
                cr, face, yr, periods, 32'($urandom));
    end
  endtask

  // Stop sending until the block has returned everything.
  task automatic test_drain_pause();
    in_valid_i <= 1'b0;
    wait (expected_results.size() == 0);
    @(posedge clk_i);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_special_cases();
    test_drain_pause();
    test_random(150);
    steady_flow = 1'b1;
    test_random(100);
    steady_flow = 1'b0;
    test_drain_pause();
    test_random(180);
    in_valid_i <= 1'b0;
    wait (expected_results.size() == 0);
    repeat (50) @(posedge clk_i);
    $display("Covered %0d bond items: price, DV01, risk and unused commands,", item_count);
    $display("%0d results, %0d with math errors, %0d saturated.", result_count,
             error_results, sat_results);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(64'd80_000_000);
    $display("FAILURE");
    $finish;
  end

endmodule
